>>> rtl/mfq_pkg.sv
// shared types and constants for the mlfq scheduler metrics block
// no dependencies
package mfq_pkg;

	localparam logic [2:0] MODE_TICK     = 3'd0;
	localparam logic [2:0] MODE_NICE     = 3'd1;
	localparam logic [2:0] MODE_SECOND   = 3'd2;
	localparam logic [2:0] MODE_PRIORITY = 3'd3;
	localparam logic [2:0] MODE_CREATE   = 3'd4;
	localparam logic [2:0] MODE_REMOVE   = 3'd5;

	localparam logic signed [5:0] NICE_MAX = 6'sd20;
	localparam logic signed [5:0] NICE_MIN = -6'sd20;

	typedef struct packed {
		logic               [5:0]  prio;
		logic signed        [5:0]  nice;
		logic signed        [31:0] rc;
	} slot_word_t;

	typedef struct packed {
		logic load_req;
		logic rd_en;
		logic rd_walk;
		logic single_wr;
		logic la_mul;
		logic la_upd;
		logic div_start;
		logic decay_ld;
		logic w_mul;
		logic w_rc;
		logic w_wr;
		logic walk_clr;
		logic walk_inc;
		logic out_ld;
	} mfq_cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       div_done;
		logic       walk_last;
		logic       out_free;
	} mfq_status_t;

endpackage

>>> rtl/mfq_div.sv
// signed restoring divider, one quotient bit per cycle, truncating toward zero
// depends on nothing; used by mfq_dp for the cpu usage decay factor
module mfq_div #(
	parameter int DW = 46
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] dividend,
	input  logic signed [31:0]   divisor,
	output logic                 done,
	output logic        [31:0]   quotient
);
	localparam int CW = $clog2(DW + 1);

	logic          busy_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [32:0]   rem_q;
	logic [DW-1:0] quo_q;
	logic [31:0]   dvs_q;
	logic [32:0]   rem_sh;
	logic          fits;
	logic [DW-1:0] quo_fin;

	assign rem_sh  = {rem_q[31:0], quo_q[DW-1]};
	assign fits    = rem_sh >= {1'b0, dvs_q};
	assign quo_fin = neg_q ? (~quo_q + DW'(1)) : quo_q;
	assign quotient = quo_fin[31:0];
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DW-1] ^ divisor[31];
			quo_q <= dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
			dvs_q <= divisor[31] ? (~divisor + 32'd1) : divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end
endmodule

>>> rtl/mfq_dp.sv
// datapath: slot table memory, valid bits, load average, shared multiplier,
// decay divider and result register; depends on mfq_pkg and mfq_div
module mfq_dp #(
	parameter int NUM_SLOTS     = 64,
	parameter int FRACTION_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mfq_pkg::mfq_cmd_t     cmd,
	output mfq_pkg::mfq_status_t  status,
	input  logic                  cfg_we,
	input  logic [5:0]            cfg_data,
	input  logic [2:0]            in_mode,
	input  logic [5:0]            in_slot,
	input  logic signed [5:0]     in_nice,
	input  logic [6:0]            in_ready,
	input  logic [5:0]            in_startp,
	output logic                  out_valid,
	input  logic                  out_take,
	output logic [5:0]            out_prio,
	output logic signed [5:0]     out_nice,
	output logic signed [24:0]    out_rc100,
	output logic signed [24:0]    out_la100
);
	import mfq_pkg::*;

	localparam int FB  = FRACTION_BITS;
	localparam int SW  = $clog2(NUM_SLOTS);
	localparam int IW  = (SW > 6) ? SW : 6;
	localparam int DW  = 32 + FB;
	localparam logic signed [31:0] FP_ONE = 32'sd1 <<< FB;
	localparam logic signed [31:0] K59    = 32'((59 * (1 << FB)) / 60);
	localparam logic        [31:0] K1     = 32'((1 << FB) / 60);
	localparam logic signed [63:0] FM1_64 = 64'((1 << FB) - 1);
	localparam logic signed [38:0] FM1_39 = 39'((1 << FB) - 1);

	// request registers
	logic [2:0]        mode_q;
	logic [5:0]        slot_q, idle_q, startp_q;
	logic signed [5:0] nice_q;
	logic [6:0]        ready_q;
	logic              inr_q;

	logic [NUM_SLOTS-1:0] valid_q;
	slot_word_t           mem [NUM_SLOTS];
	slot_word_t           rd_q;
	logic signed [31:0]   la_q, decay_q, rcn_q;
	logic signed [63:0]   prod_q;
	logic [SW-1:0]        walk_q;

	logic              out_valid_q;
	logic [5:0]        out_prio_q;
	logic signed [5:0] out_nice_q;
	logic signed [24:0] out_rc_q, out_la_q;

	logic [SW-1:0]      slot_idx, rd_addr, wr_addr;
	logic               slot_live, slot_is_idle, walk_is_idle;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_d, prod_rnd;
	logic signed [31:0] prod_tr, la_a, la_b, div_q;
	logic               div_done;
	logic               wr_en, vset, vclr;
	slot_word_t         wr_word;
	logic signed [5:0]  nice_clamped;

	function automatic logic [5:0] calc_prio(logic signed [31:0] rc, logic signed [5:0] nv);
		logic signed [31:0] rc4, p;
		logic signed [31:0] q;
		begin
			rc4 = (rc + (rc[31] ? 32'sd3 : 32'sd0)) >>> 2;
			p   = (FP_ONE * 32'sd63) - rc4 - (32'(nv) <<< (FB + 1));
			q   = p >>> FB;
			if (p[31])
				calc_prio = 6'd0;
			else if (q > 32'sd63)
				calc_prio = 6'd63;
			else
				calc_prio = q[5:0];
		end
	endfunction

	function automatic logic signed [24:0] x100(logic signed [31:0] v);
		logic signed [38:0] m, t;
		begin
			m    = 39'(v) * 39'sd100;
			t    = (m + (m[38] ? FM1_39 : 39'sd0)) >>> FB;
			x100 = t[24:0];
		end
	endfunction

	always_comb begin
		nice_clamped = in_nice;
		if (in_nice > NICE_MAX)
			nice_clamped = NICE_MAX;
		else if (in_nice < NICE_MIN)
			nice_clamped = NICE_MIN;
	end

	assign slot_idx     = inr_q ? SW'(slot_q) : '0;
	assign slot_live    = inr_q && valid_q[slot_idx];
	assign slot_is_idle = slot_q == idle_q;
	assign walk_is_idle = IW'(walk_q) == IW'(idle_q);
	assign rd_addr      = cmd.rd_walk ? walk_q : slot_idx;
	assign wr_addr      = cmd.w_wr ? walk_q : slot_idx;

	// shared multiplier: load decay in the load step, cpu usage decay in the walk
	assign mul_a    = cmd.la_mul ? K59 : decay_q;
	assign mul_b    = cmd.la_mul ? la_q : rd_q.rc;
	assign prod_d   = mul_a * mul_b;
	assign prod_rnd = (prod_q + (prod_q[63] ? FM1_64 : 64'sd0)) >>> FB;
	assign prod_tr  = prod_rnd[31:0];

	assign la_a = la_q <<< 1;
	assign la_b = la_a + FP_ONE;

	mfq_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({la_a, FB'(0)}),
		.divisor  (la_b),
		.done     (div_done),
		.quotient (div_q)
	);

	// write word selection for single-slot modes and walk write-back
	always_comb begin
		wr_en   = 1'b0;
		vset    = 1'b0;
		vclr    = 1'b0;
		wr_word = rd_q;
		if (cmd.w_wr) begin
			wr_en        = valid_q[walk_q] && !walk_is_idle;
			wr_word.rc   = rcn_q;
			wr_word.prio = calc_prio(rcn_q, rd_q.nice);
		end else if (cmd.single_wr && inr_q) begin
			case (mode_q)
				MODE_TICK: begin
					wr_en      = valid_q[slot_idx] && !slot_is_idle;
					wr_word.rc = rd_q.rc + FP_ONE;
				end
				MODE_NICE: begin
					wr_en        = valid_q[slot_idx];
					wr_word.nice = nice_q;
				end
				MODE_CREATE: begin
					wr_en   = 1'b1;
					vset    = 1'b1;
					wr_word = '{prio: startp_q, nice: '0, rc: '0};
				end
				MODE_REMOVE: begin
					wr_en   = 1'b1;
					vclr    = 1'b1;
					wr_word = '0;
				end
				default: wr_en = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_word;
		if (cmd.rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			mode_q   <= in_mode;
			slot_q   <= in_slot;
			nice_q   <= nice_clamped;
			ready_q  <= in_ready;
			startp_q <= in_startp;
			inr_q    <= 32'(in_slot) < NUM_SLOTS;
		end
		if (cmd.la_mul || cmd.w_mul)
			prod_q <= prod_d;
		if (cmd.decay_ld)
			decay_q <= (la_b == 32'sd0) ? 32'sd0 : div_q;
		if (cmd.w_rc)
			rcn_q <= (mode_q == MODE_SECOND) ?
				(prod_tr + (32'(rd_q.nice) <<< FB)) : rd_q.rc;
		if (cmd.out_ld) begin
			out_prio_q <= slot_live ? rd_q.prio : 6'd0;
			out_nice_q <= slot_live ? rd_q.nice : 6'sd0;
			out_rc_q   <= slot_live ? x100(rd_q.rc) : 25'sd0;
			out_la_q   <= x100(la_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			la_q        <= '0;
			idle_q      <= '0;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				idle_q <= cfg_data;
			if (vset)
				valid_q[slot_idx] <= 1'b1;
			else if (vclr)
				valid_q[slot_idx] <= 1'b0;
			if (cmd.la_upd)
				la_q <= prod_tr + (K1 * {25'd0, ready_q});
			if (cmd.walk_clr)
				walk_q <= '0;
			else if (cmd.walk_inc)
				walk_q <= walk_q + SW'(1);
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (out_take)
				out_valid_q <= 1'b0;
		end
	end

	assign status.mode      = mode_q;
	assign status.div_done  = div_done;
	assign status.walk_last = walk_q == SW'(NUM_SLOTS - 1);
	assign status.out_free  = !out_valid_q || out_take;

	assign out_valid = out_valid_q;
	assign out_prio  = out_prio_q;
	assign out_nice  = out_nice_q;
	assign out_rc100 = out_rc_q;
	assign out_la100 = out_la_q;
endmodule

>>> rtl/mfq_ctrl.sv
// controller state machine sequencing requests through the datapath
// depends on mfq_pkg
module mfq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mfq_pkg::mfq_status_t status,
	output mfq_pkg::mfq_cmd_t    cmd
);
	import mfq_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_RD     = 13'b0000000000010,
		ST_SMOD   = 13'b0000000000100,
		ST_LMUL   = 13'b0000000001000,
		ST_LUPD   = 13'b0000000010000,
		ST_DSTART = 13'b0000000100000,
		ST_DWAIT  = 13'b0000001000000,
		ST_WRD    = 13'b0000010000000,
		ST_WDAT   = 13'b0000100000000,
		ST_WRC    = 13'b0001000000000,
		ST_WWR    = 13'b0010000000000,
		ST_ORD    = 13'b0100000000000,
		ST_FIN    = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				if (status.mode == MODE_SECOND)
					state_d = ST_LMUL;
				else if (status.mode == MODE_PRIORITY) begin
					cmd.walk_clr = 1'b1;
					state_d      = ST_WRD;
				end else
					state_d = ST_SMOD;
			end
			ST_SMOD: begin
				cmd.single_wr = 1'b1;
				state_d       = ST_ORD;
			end
			ST_LMUL: begin
				cmd.la_mul = 1'b1;
				state_d    = ST_LUPD;
			end
			ST_LUPD: begin
				cmd.la_upd = 1'b1;
				state_d    = ST_DSTART;
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (status.div_done) begin
					cmd.decay_ld = 1'b1;
					cmd.walk_clr = 1'b1;
					state_d      = ST_WRD;
				end
			end
			ST_WRD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_walk = 1'b1;
				state_d     = ST_WDAT;
			end
			ST_WDAT: begin
				cmd.w_mul = 1'b1;
				state_d   = ST_WRC;
			end
			ST_WRC: begin
				cmd.w_rc = 1'b1;
				state_d  = ST_WWR;
			end
			ST_WWR: begin
				cmd.w_wr = 1'b1;
				if (status.walk_last)
					state_d = ST_ORD;
				else begin
					cmd.walk_inc = 1'b1;
					state_d      = ST_WRD;
				end
			end
			ST_ORD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end
endmodule

>>> rtl/mlfq_fixed_point_scheduler_metrics.sv
// top level of the mlfq scheduler metrics block: stream ports, controller, datapath
// depends on mfq_pkg, mfq_ctrl, mfq_dp (and mfq_div through mfq_dp)
// tick, set nice, create, remove, query: the request is registered, the slot is read (and written
//   for tick, set nice, create, remove), read again, and the result register loads once the output is free
// priority recompute and second update walk every slot of the table; the second update first updates
//   the load average and runs the divider; one request in flight, a new one is taken while
//   the last result still waits
// reset (arst_n low, asynchronous) clears valid bits, load average, idle slot, control
module mlfq_fixed_point_scheduler_metrics #(
	parameter int NUM_SLOTS     = 64,
	parameter int FRACTION_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[2:0], thread_slot[8:3], nice_value[14:9], ready_count[21:15],
	// start_priority[27:22], zero fill above
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// priority_out[5:0], nice_out[11:6], cpu_usage_x100[36:12],
	// load_avg_x100[61:37], zero fill above
	output logic [63:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data       // idle_slot
);
	import mfq_pkg::*;

	mfq_cmd_t    cmd;
	mfq_status_t status;

	logic [5:0]         o_prio;
	logic signed [5:0]  o_nice;
	logic signed [24:0] o_rc, o_la;

	// config register is always writable; the user must write only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	mfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	mfq_dp #(
		.NUM_SLOTS     (NUM_SLOTS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.in_mode   (s_axis_tdata[2:0]),
		.in_slot   (s_axis_tdata[8:3]),
		.in_nice   (s_axis_tdata[14:9]),
		.in_ready  (s_axis_tdata[21:15]),
		.in_startp (s_axis_tdata[27:22]),
		.out_valid (m_axis_tvalid),
		.out_take  (m_axis_tready),
		.out_prio  (o_prio),
		.out_nice  (o_nice),
		.out_rc100 (o_rc),
		.out_la100 (o_la)
	);

	// result word, fields from the low end
	assign m_axis_tdata = {2'b00, o_la, o_rc, o_nice, o_prio};
endmodule

>>> rtl/mfq_chk.sv
// port-level checker for the mlfq scheduler metrics block and its bind
// depends on the top level port list only
module mfq_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);
	// a pending result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while busy");

	// a new result only appears while a request is being worked on
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without request");

	// stored nice stays clamped
	a_nice_rng: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[11:6]) >= -6'sd20) &&
			($signed(m_axis_tdata[11:6]) <= 6'sd20))
		else $error("nice out of range");
endmodule

bind mlfq_fixed_point_scheduler_metrics mfq_chk u_chk (.*);

>>> test/mlfq_fixed_point_scheduler_metrics_tb.sv
// testbench for mlfq_fixed_point_scheduler_metrics: directed table, then random requests
// checks each result against its table value or a local fixed-point predictor; depends on mfq_pkg and the rtl
`timescale 1ns / 100ps

module mlfq_fixed_point_scheduler_metrics_tb;
	import mfq_pkg::*;

	localparam logic [2:0] MODE_QUERY = 3'd6;
	localparam logic [2:0] MODE_SPARE = 3'd7;   // unused code, behaves as a query
	localparam int         SLOTS      = 64;
	localparam longint     FP         = 64'sd1 << 14;
	localparam int         STALL_LIMIT = 5000;

	typedef struct packed {
		logic        [5:0]  prio;
		logic signed [5:0]  nice;
		logic signed [24:0] rc100;
		logic signed [24:0] la100;
	} metrics_t;

	typedef struct packed {
		logic        [2:0] mode;
		logic        [5:0] slot;
		logic signed [5:0] nv;
		logic        [6:0] ready;
		logic        [5:0] start_prio;
		logic              typed;     // expected value written into the row
		metrics_t          want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;     // mode, thread_slot, nice_value, ready_count, start_priority
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;          // priority_out, nice_out, cpu_usage_x100, load_avg_x100
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = '0;         // idle_slot

	mlfq_fixed_point_scheduler_metrics uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow copy of the slot table
	bit                slot_live [SLOTS];
	logic signed [5:0] slot_nice_q [SLOTS];
	int                slot_cpu [SLOTS];
	logic        [5:0] slot_prio [SLOTS];
	int                load_fp;
	logic        [5:0] idle_q;

	metrics_t pending_metrics[$];
	int       fail_count = 0;
	int       result_count = 0;
	int       stall_cycles = 0;
	bit       quiet;                    // no idling on either side
	int       second_count;

	// wrap to a signed 32-bit word
	function automatic longint wrap_word(longint v);
		int t;
		t = int'(v);
		return longint'(t);
	endfunction

	function automatic void refresh_priority(int i);
		longint p;
		if (i == idle_q)
			return;
		p = 63 * FP - longint'(slot_cpu[i]) / 4 - 2 * longint'(slot_nice_q[i]) * FP;
		p = wrap_word(p) / FP;
		if (p > 63) p = 63;
		if (p < 0) p = 0;
		slot_prio[i] = p[5:0];
	endfunction

	// apply one request to the shadow table and return the metrics it should produce
	function automatic metrics_t apply_request(logic [2:0] mode, logic [5:0] slot,
		logic signed [5:0] nv, logic [6:0] ready, logic [5:0] sp);
		longint la, a, b, decay, rc, tmp;
		logic signed [5:0] n;
		metrics_t m;
		int s;
		s = slot;
		case (mode)
			MODE_TICK: begin
				if (slot_live[s] && s != idle_q)
					slot_cpu[s] = int'(wrap_word(longint'(slot_cpu[s]) + FP));
			end
			MODE_NICE: begin
				if (slot_live[s]) begin
					n = nv;
					if (n > NICE_MAX) n = NICE_MAX;
					if (n < NICE_MIN) n = NICE_MIN;
					slot_nice_q[s] = n;
				end
			end
			MODE_SECOND: begin
				// load = 59/60 load + ready/60, then decay every live slot but the idle one
				la = wrap_word(wrap_word((59 * FP / 60) * longint'(load_fp) / FP)
					+ (FP / 60) * longint'(ready));
				load_fp = int'(la);
				a = wrap_word(la * 2);
				b = wrap_word(a + FP);
				decay = (b == 0) ? 0 : wrap_word((a * FP) / b);
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_live[i] && i != idle_q) begin
						rc = wrap_word((decay * longint'(slot_cpu[i])) / FP);
						rc = wrap_word(rc + longint'(slot_nice_q[i]) * FP);
						slot_cpu[i] = int'(rc);
						refresh_priority(i);
					end
				end
			end
			MODE_PRIORITY: begin
				for (int i = 0; i < SLOTS; i++)
					if (slot_live[i])
						refresh_priority(i);
			end
			MODE_CREATE: begin
				slot_live[s] = 1'b1;
				slot_nice_q[s] = '0;
				slot_cpu[s] = 0;
				slot_prio[s] = sp;
			end
			MODE_REMOVE: begin
				slot_live[s] = 1'b0;
				slot_nice_q[s] = '0;
				slot_cpu[s] = 0;
				slot_prio[s] = '0;
			end
			default: ;
		endcase
		tmp = (longint'(load_fp) * 100) / FP;
		m.la100 = tmp[24:0];
		if (slot_live[s]) begin
			tmp = (longint'(slot_cpu[s]) * 100) / FP;
			m.rc100 = tmp[24:0];
			m.prio = slot_prio[s];
			m.nice = slot_nice_q[s];
		end else begin
			m.rc100 = '0;
			m.prio = '0;
			m.nice = '0;
		end
		return m;
	endfunction

	// one request on the slave side; optional idle burst first, valid held across back-to-back
	task automatic send_request(logic [2:0] mode, logic [5:0] slot, logic signed [5:0] nv,
		logic [6:0] ready, logic [5:0] sp, bit typed, metrics_t want);
		metrics_t m;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, sp, ready, nv, slot, mode};
		do @(posedge clk); while (!s_axis_tready);
		m = apply_request(mode, slot, nv, ready, sp);
		if (mode == MODE_SECOND)
			second_count++;
		pending_metrics.push_back(typed ? want : m);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_metrics.size() != 0) @(posedge clk);
	endtask

	// register write only with the block idle
	task automatic write_idle_slot(logic [5:0] v);
		drain_results();
		repeat (10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		idle_q = v;
	endtask

	task automatic random_request();
		logic [2:0] mode;
		logic [5:0] slot;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) mode = MODE_TICK;
		else if (pick < 42) mode = MODE_NICE;
		else if (pick < 50) mode = MODE_SECOND;
		else if (pick < 56) mode = MODE_PRIORITY;
		else if (pick < 72) mode = MODE_CREATE;
		else if (pick < 78) mode = MODE_REMOVE;
		else if (pick < 97) mode = MODE_QUERY;
		else mode = MODE_SPARE;
		// mostly a small working set so slots stay alive and accumulate cpu
		slot = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
		send_request(mode, slot, 6'($urandom), 7'($urandom), 6'($urandom), 1'b0, '0);
	endtask

	// receiver ready: bursts of stall between runs of ready
	initial begin
		@(posedge arst_n);
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (!quiet) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		metrics_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.prio  = m_axis_tdata[5:0];
			got.nice  = m_axis_tdata[11:6];
			got.rc100 = m_axis_tdata[36:12];
			got.la100 = m_axis_tdata[61:37];
			result_count++;
			if (pending_metrics.size() == 0) begin
				$error("result with nothing expected: %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_metrics.pop_front();
				if (got.prio !== want.prio) begin
					$error("priority_out expected %0d got %0d", want.prio, got.prio);
					fail_count++;
				end
				if (got.nice !== want.nice) begin
					$error("nice_out expected %0d got %0d", want.nice, got.nice);
					fail_count++;
				end
				if (got.rc100 !== want.rc100) begin
					$error("cpu_usage_x100 expected %0d got %0d", want.rc100, got.rc100);
					fail_count++;
				end
				if (got.la100 !== want.la100) begin
					$error("load_avg_x100 expected %0d got %0d", want.la100, got.la100);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_metrics.size());
			$display("FAIL mlfq_fixed_point_scheduler_metrics");
			$finish;
		end
	end

	stim_row_t rows [] = '{
		// empty table reads as zero
		'{MODE_QUERY,    6'd5,  6'sd0,   7'd0,   6'd0,  1'b1, '{6'd0, 6'sd0, 25'sd0, 25'sd0}},
		'{MODE_CREATE,   6'd5,  6'sd0,   7'd0,   6'd63, 1'b1, '{6'd63, 6'sd0, 25'sd0, 25'sd0}},
		'{MODE_CREATE,   6'd63, 6'sd0,   7'd0,   6'd0,  1'b1, '{6'd0, 6'sd0, 25'sd0, 25'sd0}},
		'{MODE_TICK,     6'd5,  6'sd0,   7'd0,   6'd0,  1'b1, '{6'd63, 6'sd0, 25'sd100, 25'sd0}},
		'{MODE_TICK,     6'd5,  6'sd0,   7'd0,   6'd0,  1'b1, '{6'd63, 6'sd0, 25'sd200, 25'sd0}},
		// nice clamps at both ends, priority left alone
		'{MODE_NICE,     6'd5,  6'sd31,  7'd0,   6'd0,  1'b1, '{6'd63, 6'sd20, 25'sd200, 25'sd0}},
		'{MODE_NICE,     6'd5,  -6'sd32, 7'd0,   6'd0,  1'b1, '{6'd63, -6'sd20, 25'sd200, 25'sd0}},
		'{MODE_NICE,     6'd63, -6'sd20, 7'd0,   6'd0,  1'b0, '0},
		// idle slot: tick has no effect; invalid slot ignores nice
		'{MODE_TICK,     6'd3,  6'sd0,   7'd0,   6'd0,  1'b1, '{6'd0, 6'sd0, 25'sd0, 25'sd0}},
		'{MODE_CREATE,   6'd3,  6'sd0,   7'd0,   6'd10, 1'b1, '{6'd10, 6'sd0, 25'sd0, 25'sd0}},
		'{MODE_TICK,     6'd3,  6'sd0,   7'd0,   6'd0,  1'b1, '{6'd10, 6'sd0, 25'sd0, 25'sd0}},
		'{MODE_NICE,     6'd9,  6'sd5,   7'd0,   6'd0,  1'b1, '{6'd0, 6'sd0, 25'sd0, 25'sd0}},
		'{MODE_PRIORITY, 6'd5,  6'sd0,   7'd0,   6'd0,  1'b0, '0},
		'{MODE_SECOND,   6'd5,  6'sd0,   7'd64,  6'd0,  1'b0, '0},
		'{MODE_SECOND,   6'd63, 6'sd0,   7'd127, 6'd0,  1'b0, '0},
		'{MODE_SECOND,   6'd3,  6'sd0,   7'd0,   6'd0,  1'b0, '0},
		'{MODE_PRIORITY, 6'd63, 6'sd0,   7'd0,   6'd0,  1'b0, '0},
		'{MODE_REMOVE,   6'd5,  6'sd0,   7'd0,   6'd0,  1'b0, '0},
		'{MODE_REMOVE,   6'd5,  6'sd0,   7'd0,   6'd0,  1'b0, '0},
		'{MODE_TICK,     6'd5,  6'sd0,   7'd0,   6'd0,  1'b0, '0},
		'{MODE_SPARE,    6'd63, 6'sd0,   7'd0,   6'd0,  1'b0, '0},
		'{MODE_CREATE,   6'd0,  6'sd0,   7'd0,   6'd31, 1'b0, '0},
		'{MODE_TICK,     6'd0,  6'sd0,   7'd0,   6'd0,  1'b0, '0},
		'{MODE_SECOND,   6'd0,  6'sd0,   7'd1,   6'd0,  1'b0, '0},
		'{MODE_QUERY,    6'd0,  6'sd0,   7'd0,   6'd0,  1'b0, '0}
	};

	initial begin
		logic [5:0] phase_idle [3];
		second_count = 0;
		quiet = 1'b0;
		load_fp = 0;
		idle_q = '0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_nice_q[i] = '0;
			slot_cpu[i] = 0;
			slot_prio[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part runs with slot 3 as the idle thread
		write_idle_slot(6'd3);
		foreach (rows[r])
			send_request(rows[r].mode, rows[r].slot, rows[r].nv, rows[r].ready,
				rows[r].start_prio, rows[r].typed, rows[r].want);

		// random part over three idle-slot settings, extremes included
		phase_idle[0] = 6'd63;
		phase_idle[1] = 6'd0;
		phase_idle[2] = 6'($urandom_range(1, 7));
		for (int p = 0; p < 3; p++) begin
			write_idle_slot(phase_idle[p]);
			for (int k = 0; k < 150; k++) begin
				if (p == 0 && k == 75)
					drain_results();   // let the sender sit until the output side is empty
				if (p == 2 && k == 90)
					quiet = 1'b1;
				random_request();
			end
		end

		drain_results();
		repeat (400) @(posedge clk);
		$display("covered %0d results, %0d second updates, idle slot at 3, 63, 0 and %0d",
			result_count, second_count, phase_idle[2]);
		if (fail_count == 0 && pending_metrics.size() == 0)
			$display("PASS mlfq_fixed_point_scheduler_metrics");
		else
			$display("FAIL mlfq_fixed_point_scheduler_metrics");
		$finish;
	end

endmodule

>>> mlfq_fixed_point_scheduler_metrics.f
rtl/mfq_pkg.sv
rtl/mfq_div.sv
rtl/mfq_dp.sv
rtl/mfq_ctrl.sv
rtl/mlfq_fixed_point_scheduler_metrics.sv
rtl/mfq_chk.sv
test/mlfq_fixed_point_scheduler_metrics_tb.sv
